// ----- rtl/servo_packet_deframer_macros.svh -----
// Assertion macros shared by the servo packet deframer RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef SERVO_PACKET_DEFRAMER_MACROS_SVH
`define SERVO_PACKET_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define SVPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svpd: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SVPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svpd: next-cycle check failed");

`else

`define SVPD_ASSERT_IMP(label, ante, cons)
`define SVPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/svpd_pkg.sv -----
// Shared types and constants of the servo packet deframer.
// No dependencies; used by the channel interfaces and the top level.
package svpd_pkg;

    // Receive buffer geometry (power of two)
    localparam int BUF_DEPTH = 512;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int LVL_W     = BUF_AW + 1;

    // Parameter store geometry
    localparam int PAR_DEPTH = 256;
    localparam int PAR_AW    = $clog2(PAR_DEPTH);

    // Framing constants
    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] LEN_MIN     = 8'd2;
    localparam logic [7:0] LEN_MAX     = 8'd250;
    localparam logic [7:0] FRAME_EXTRA = 8'd4;
    localparam logic [7:0] PKT_OVHD    = LEN_MIN + FRAME_EXTRA;

    // Byte offsets from the first header byte
    localparam int OFF_ID   = 2;
    localparam int OFF_LEN  = 3;
    localparam int OFF_CODE = 4;
    localparam int OFF_PAR  = 5;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_TAKE   = 2'd1,
        FN_READ   = 2'd2,
        FN_RSVD   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STS_APPENDED = 3'd0,
        STS_FULL     = 3'd1,
        STS_NONE     = 3'd2,
        STS_TAKEN    = 3'd3,
        STS_READ     = 3'd4
    } status_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] rx_byte;
        logic [7:0] param_index;
    } cmd_beat_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       packet_id;
        logic [7:0]       instruction_code;
        logic [7:0]       param_count;
        logic [7:0]       param_byte;
        logic [LVL_W-1:0] buffer_level;
    } rsp_beat_t;

endpackage

// ----- rtl/svpd_cmd_if.sv -----
// Command channel of the servo packet deframer: valid/ready plus one command beat.
// Depends on svpd_pkg.
interface svpd_cmd_if
    import svpd_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/svpd_rsp_if.sv -----
// Response channel of the servo packet deframer: valid/ready plus one result beat.
// Depends on svpd_pkg.
interface svpd_rsp_if
    import svpd_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/servo_packet_deframer.sv -----
// Servo packet deframer: circular receive buffer, header scan, checksum, parameter store.
// Depends on svpd_pkg, svpd_cmd_if, svpd_rsp_if and servo_packet_deframer_macros.svh.
//
//   chan  dir  beat fields
//   cmd   in   func, rx_byte, param_index
//   rsp   out  status, packet_id, instruction_code, param_count, param_byte, buffer_level
//
// Append, read and unused commands: accept, then load of the response register.
// A take reads the buffer through its one registered read port. A bad length or checksum
// drops one byte and restarts the scan, so the worst case is a full buffer that costs one
// checksum pass of up to 251 bytes for each byte it drops. Both stores hold no reset
// state; reset clears the state, head, level, valid flag and latched fields. The response
// register holds one result; the next command is taken once it is loaded.
`include "servo_packet_deframer_macros.svh"

module servo_packet_deframer
    import svpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    svpd_cmd_if.sink   cmd,
    svpd_rsp_if.source rsp
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RESP = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_LEN  = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_CHK  = 7'b0100000,
        S_COPY = 7'b1000000
    } state_t;

    // Storage
    logic [7:0] rx_mem [BUF_DEPTH];
    logic [7:0] pm_mem [PAR_DEPTH];

    // Control and datapath registers
    state_t           state_reg, state_next;
    logic             wt_reg, wt_next;
    logic [BUF_AW-1:0] off_reg, off_next;
    logic             prev_ff_reg, prev_ff_next;
    logic [BUF_AW-1:0] head_reg, head_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [7:0]       size_reg, size_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       id_tmp_reg, id_tmp_next;
    logic [7:0]       code_tmp_reg, code_tmp_next;
    logic [7:0]       last_id_reg, last_id_next;
    logic [7:0]       last_code_reg, last_code_next;
    logic [7:0]       last_count_reg, last_count_next;
    status_t          res_status_reg, res_status_next;
    logic             res_rd_reg, res_rd_next;
    logic             res_idx_ok_reg, res_idx_ok_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_beat_t        rsp_beat_reg, rsp_beat_next;

    // Memory ports
    logic              rx_wr_en;
    logic [BUF_AW-1:0] rx_wr_addr;
    logic [7:0]        rx_wr_data;
    logic              rx_rd_en;
    logic [BUF_AW-1:0] rx_rd_addr;
    logic [7:0]        rx_rdata_reg;
    logic              pm_wr_en;
    logic [PAR_AW-1:0] pm_wr_addr;
    logic [PAR_AW-1:0] pm_rd_addr;
    logic              pm_rd_en;
    logic [7:0]        pm_rdata_reg;

    // Helpers
    logic              cmd_acc;
    logic              rsp_free;
    logic [BUF_AW-1:0] pos_w;
    logic [LVL_W-1:0]  lvl_drop_w;
    logic [7:0]        size_w;
    logic              last_off_w;
    logic [7:0]        rd_byte;
    logic              append_ok_w;
    logic              copy_size_ok_w;

    assign cmd_acc    = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.payload = rsp_beat_reg;
    assign rsp_free   = !rsp_valid_reg || rsp.ready;

    assign rd_byte    = rx_rdata_reg;
    assign pos_w      = off_reg - BUF_AW'(1);
    assign lvl_drop_w = level_reg - LVL_W'(pos_w);
    assign size_w     = rd_byte + FRAME_EXTRA;
    assign last_off_w = ((LVL_W'(off_reg) + LVL_W'(1)) == level_reg);

    // Conditions watched by the checks
    assign append_ok_w    = cmd_acc && (cmd.payload.func == FN_APPEND) &&
                            (level_reg != LVL_W'(BUF_DEPTH));
    assign copy_size_ok_w = (last_count_reg != 8'd0) &&
                            (size_reg == last_count_reg + PKT_OVHD);

    // Receive buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rx_wr_en)
        begin
            rx_mem[rx_wr_addr] <= rx_wr_data;
        end
        if (rx_rd_en)
        begin
            rx_rdata_reg <= rx_mem[rx_rd_addr];
        end
    end

    // Parameter store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pm_wr_en)
        begin
            pm_mem[pm_wr_addr] <= rd_byte;
        end
        if (pm_rd_en)
        begin
            pm_rdata_reg <= pm_mem[pm_rd_addr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        wt_next         = wt_reg;
        off_next        = off_reg;
        prev_ff_next    = prev_ff_reg;
        head_next       = head_reg;
        level_next      = level_reg;
        size_next       = size_reg;
        sum_next        = sum_reg;
        id_tmp_next     = id_tmp_reg;
        code_tmp_next   = code_tmp_reg;
        last_id_next    = last_id_reg;
        last_code_next  = last_code_reg;
        last_count_next = last_count_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        res_idx_ok_next = res_idx_ok_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_beat_next   = rsp_beat_reg;

        rx_wr_en   = 1'b0;
        rx_wr_addr = head_reg + level_reg[BUF_AW-1:0];
        rx_wr_data = cmd.payload.rx_byte;
        rx_rd_en   = 1'b0;
        rx_rd_addr = head_reg + off_reg;
        pm_wr_en   = 1'b0;
        pm_wr_addr = PAR_AW'(off_reg - BUF_AW'(OFF_PAR));
        pm_rd_en   = 1'b0;
        pm_rd_addr = cmd.payload.param_index;

        // Retire the response beat once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    res_rd_next = 1'b0;
                    state_next  = S_RESP;
                    unique case (cmd.payload.func)
                        FN_APPEND:
                        begin
                            if (level_reg == LVL_W'(BUF_DEPTH))
                            begin
                                res_status_next = STS_FULL;
                            end
                            else
                            begin
                                rx_wr_en        = 1'b1;
                                level_next      = level_reg + LVL_W'(1);
                                res_status_next = STS_APPENDED;
                            end
                        end
                        FN_TAKE:
                        begin
                            res_status_next = STS_NONE;
                            if (level_reg >= LVL_W'(2))
                            begin
                                state_next   = S_SCAN;
                                off_next     = '0;
                                prev_ff_next = 1'b0;
                                wt_next      = 1'b0;
                            end
                        end
                        FN_READ:
                        begin
                            pm_rd_en        = 1'b1;
                            res_rd_next     = 1'b1;
                            res_idx_ok_next = (cmd.payload.param_index < last_count_reg);
                            res_status_next = STS_READ;
                        end
                        FN_RSVD:
                        begin
                            res_status_next = STS_NONE;
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                // Load the response register when it is free
                if (rsp_free)
                begin
                    rsp_valid_next                 = 1'b1;
                    rsp_beat_next.status           = res_status_reg;
                    rsp_beat_next.packet_id        = last_id_reg;
                    rsp_beat_next.instruction_code = last_code_reg;
                    rsp_beat_next.param_count      = last_count_reg;
                    rsp_beat_next.param_byte       = (res_rd_reg && res_idx_ok_reg) ?
                                                     pm_rdata_reg : 8'd0;
                    rsp_beat_next.buffer_level     = level_reg;
                    state_next                     = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (!wt_reg)
                begin
                    rx_rd_en = 1'b1;
                    wt_next  = 1'b1;
                end
                else
                begin
                    wt_next = 1'b0;
                    if (prev_ff_reg && (rd_byte == HDR_BYTE))
                    begin
                        // Header found: drop the bytes in front of it
                        head_next  = head_reg + pos_w;
                        level_next = lvl_drop_w;
                        if (lvl_drop_w < LVL_W'(FRAME_EXTRA))
                        begin
                            res_status_next = STS_NONE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            off_next   = BUF_AW'(OFF_LEN);
                            state_next = S_LEN;
                        end
                    end
                    else if (last_off_w)
                    begin
                        // No header: empty the buffer, keep a trailing 0xFF
                        if (rd_byte == HDR_BYTE)
                        begin
                            head_next  = head_reg + level_reg[BUF_AW-1:0] - BUF_AW'(1);
                            level_next = LVL_W'(1);
                        end
                        else
                        begin
                            head_next  = head_reg + level_reg[BUF_AW-1:0];
                            level_next = '0;
                        end
                        res_status_next = STS_NONE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        prev_ff_next = (rd_byte == HDR_BYTE);
                        off_next     = off_reg + BUF_AW'(1);
                    end
                end
            end

            S_LEN:
            begin
                if (!wt_reg)
                begin
                    rx_rd_en = 1'b1;
                    wt_next  = 1'b1;
                end
                else
                begin
                    wt_next = 1'b0;
                    if ((rd_byte < LEN_MIN) || (rd_byte > LEN_MAX))
                    begin
                        // Bad length: drop one byte and rescan (at least three remain)
                        head_next    = head_reg + BUF_AW'(1);
                        level_next   = level_reg - LVL_W'(1);
                        off_next     = '0;
                        prev_ff_next = 1'b0;
                        state_next   = S_SCAN;
                    end
                    else if (level_reg < LVL_W'(size_w))
                    begin
                        // Partial packet: stay aligned at the header
                        res_status_next = STS_NONE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        size_next  = size_w;
                        sum_next   = '0;
                        off_next   = BUF_AW'(OFF_ID);
                        state_next = S_SUM;
                    end
                end
            end

            S_SUM:
            begin
                if (!wt_reg)
                begin
                    rx_rd_en = 1'b1;
                    wt_next  = 1'b1;
                end
                else
                begin
                    wt_next  = 1'b0;
                    sum_next = sum_reg + rd_byte;
                    if (off_reg == BUF_AW'(OFF_ID))
                    begin
                        id_tmp_next = rd_byte;
                    end
                    if (off_reg == BUF_AW'(OFF_CODE))
                    begin
                        code_tmp_next = rd_byte;
                    end
                    if (off_reg == BUF_AW'(size_reg - 8'd2))
                    begin
                        off_next   = BUF_AW'(size_reg - 8'd1);
                        state_next = S_CHK;
                    end
                    else
                    begin
                        off_next = off_reg + BUF_AW'(1);
                    end
                end
            end

            S_CHK:
            begin
                if (!wt_reg)
                begin
                    rx_rd_en = 1'b1;
                    wt_next  = 1'b1;
                end
                else
                begin
                    wt_next = 1'b0;
                    if (~sum_reg == rd_byte)
                    begin
                        last_id_next    = id_tmp_reg;
                        last_code_next  = code_tmp_reg;
                        last_count_next = size_reg - PKT_OVHD;
                        if (size_reg == PKT_OVHD)
                        begin
                            head_next       = head_reg + BUF_AW'(size_reg);
                            level_next      = level_reg - LVL_W'(size_reg);
                            res_status_next = STS_TAKEN;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            off_next   = BUF_AW'(OFF_PAR);
                            state_next = S_COPY;
                        end
                    end
                    else
                    begin
                        // Bad checksum: drop one byte and rescan
                        head_next    = head_reg + BUF_AW'(1);
                        level_next   = level_reg - LVL_W'(1);
                        off_next     = '0;
                        prev_ff_next = 1'b0;
                        state_next   = S_SCAN;
                    end
                end
            end

            S_COPY:
            begin
                if (!wt_reg)
                begin
                    rx_rd_en = 1'b1;
                    wt_next  = 1'b1;
                end
                else
                begin
                    wt_next  = 1'b0;
                    pm_wr_en = 1'b1;
                    if (off_reg == BUF_AW'(size_reg - 8'd2))
                    begin
                        // Last parameter copied: remove the packet
                        head_next       = head_reg + BUF_AW'(size_reg);
                        level_next      = level_reg - LVL_W'(size_reg);
                        res_status_next = STS_TAKEN;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        off_next = off_reg + BUF_AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wt_reg         <= 1'b0;
            head_reg       <= '0;
            level_reg      <= '0;
            last_id_reg    <= '0;
            last_code_reg  <= '0;
            last_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wt_reg         <= wt_next;
            head_reg       <= head_next;
            level_reg      <= level_next;
            last_id_reg    <= last_id_next;
            last_code_reg  <= last_code_next;
            last_count_reg <= last_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        prev_ff_reg    <= prev_ff_next;
        size_reg       <= size_next;
        sum_reg        <= sum_next;
        id_tmp_reg     <= id_tmp_next;
        code_tmp_reg   <= code_tmp_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        res_idx_ok_reg <= res_idx_ok_next;
        rsp_beat_reg   <= rsp_beat_next;
    end

    // Checks
    `SVPD_ASSERT_IMP(a_level_bound, 1'b1, level_reg <= LVL_W'(BUF_DEPTH))
    `SVPD_ASSERT_NEXT(a_append_grows, append_ok_w, level_reg == $past(level_reg) + LVL_W'(1))
    `SVPD_ASSERT_IMP(a_scan_in_range, state_reg == S_SCAN, LVL_W'(off_reg) < level_reg)
    `SVPD_ASSERT_IMP(a_copy_count, state_reg == S_COPY, copy_size_ok_w)

endmodule
